[hdl/sn2d_pkg.sv]
`default_nettype none
package sn2d_pkg;

    // Hash primes and the hash multiplier.
    localparam logic [63:0] PRIME_X   = 64'h5205402B9270C86F;
    localparam logic [63:0] PRIME_Y   = 64'h598CD327003817B5;
    localparam logic [63:0] HASH_MULT = 64'h53A3F72DEEC546F5;

    // Skew, unskew and falloff constants in Q.22; the output normalizer in Q.16.
    localparam logic signed [23:0] Q22_SKEW              = 24'sd1535222;
    localparam logic signed [23:0] Q22_ROOT_HALF         = 24'sd2965821;
    localparam logic signed [23:0] Q22_ROOT_THREE_HALVES = 24'sd5136952;
    localparam logic signed [23:0] Q22_UNSKEW            = -24'sd886361;
    localparam logic signed [23:0] Q22_UNSKEW_P1         = 24'sd3307943;
    localparam logic signed [23:0] Q22_DIAG              = 24'sd2421583;
    localparam logic signed [23:0] Q22_RSQ               = 24'sd2097152;
    localparam logic signed [25:0] Q22_A1_SLOPE          = -26'sd13231773;
    localparam logic signed [23:0] Q22_A1_BASE           = -24'sd2796203;
    localparam logic signed [23:0] Q16_NORM_INV          = 24'sd6542908;

    // Gradient components in Q1.22.
    localparam logic signed [23:0] GC = 24'sd1605091;
    localparam logic signed [23:0] GS = 24'sd3875032;
    localparam logic signed [23:0] GA = 24'sd547467;
    localparam logic signed [23:0] GB = 24'sd4158421;
    localparam logic signed [23:0] GM = 24'sd2553330;
    localparam logic signed [23:0] GD = 24'sd3327565;

    typedef logic signed [23:0] grad_t;
    typedef logic signed [25:0] ofs_t;
    typedef logic [23:0]        fall_t;
    typedef logic signed [60:0] contrib_t;
    typedef logic signed [51:0] slope_t;

    function automatic logic [4:0] mod24(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (r >= 7'd96)
            r = r - 7'd96;
        if (r >= 7'd48)
            r = r - 7'd48;
        if (r >= 7'd24)
            r = r - 7'd24;
        return r[4:0];
    endfunction

    function automatic grad_t grad_x(input logic [4:0] k);
        grad_t g;
        case (k)
            5'd0:  g = GC;
            5'd1:  g = GS;
            5'd2:  g = GS;
            5'd3:  g = GC;
            5'd4:  g = -GC;
            5'd5:  g = -GS;
            5'd6:  g = -GS;
            5'd7:  g = -GC;
            5'd8:  g = GA;
            5'd9:  g = GM;
            5'd10: g = GD;
            5'd11: g = GB;
            5'd12: g = GB;
            5'd13: g = GD;
            5'd14: g = GM;
            5'd15: g = GA;
            5'd16: g = -GA;
            5'd17: g = -GM;
            5'd18: g = -GD;
            5'd19: g = -GB;
            5'd20: g = -GB;
            5'd21: g = -GD;
            5'd22: g = -GM;
            5'd23: g = -GA;
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic grad_t grad_y(input logic [4:0] k);
        grad_t g;
        case (k)
            5'd0:  g = GS;
            5'd1:  g = GC;
            5'd2:  g = -GC;
            5'd3:  g = -GS;
            5'd4:  g = -GS;
            5'd5:  g = -GC;
            5'd6:  g = GC;
            5'd7:  g = GS;
            5'd8:  g = GB;
            5'd9:  g = GD;
            5'd10: g = GM;
            5'd11: g = GA;
            5'd12: g = -GA;
            5'd13: g = -GM;
            5'd14: g = -GD;
            5'd15: g = -GB;
            5'd16: g = -GB;
            5'd17: g = -GD;
            5'd18: g = -GM;
            5'd19: g = -GA;
            5'd20: g = GA;
            5'd21: g = GM;
            5'd22: g = GD;
            5'd23: g = GB;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

[hdl/simplex_noise_2d.sv]
`default_nettype none
// 2D gradient noise of the fast OpenSimplex2 kind, all in fixed point. Each input item is
// one point (x and y in signed Q16.16); each output item is one noise value in signed
// Q1.15, saturated. The block is a 14-stage pipeline and takes one item per clock cycle
// when the output side keeps up. Each stage has its own valid bit and advances when it
// is empty or when the stage after it advances, so a stall on the output only stops the
// stages that are full, and bubbles still get squeezed out while a result waits to be
// taken. The throughput is set by the three corner units working in parallel; each
// corner's 64-bit hash multiply is split into 32-bit partial products over two stages.
// noise_seed (register 0) is xored into every corner hash and orientation_mode (register
// 1, bit 0) selects the standard skew (0) or the rotation that improves the X direction
// (1). Both reset to zero and should be written only while no item is in flight.
module simplex_noise_2d (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // x_coord [31:0], y_coord [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // noise_value [15:0]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import sn2d_pkg::*;

    localparam logic REG_SEED = 1'b0;
    localparam logic REG_MODE = 1'b1;

    logic [63:0]        seed_reg;
    logic               mode_reg;
    logic [14:1]        valid_reg;
    logic [14:1]        valid_in;
    logic [15:1]        en;

    logic signed [19:0] cell_x, cell_y;
    logic [21:0]        frac_x, frac_y;
    logic [63:0]        hash0, hash1, hash2;
    ofs_t               dx0, dy0, dx1, dy1, dx2, dy2;
    slope_t             slope;
    fall_t              a0, a1, a2;
    contrib_t           c0, c1, c2;

    logic signed [62:0] acc_reg;
    logic signed [62:0] acc_rnd;
    logic signed [64:0] vn_reg;
    logic signed [65:0] vn_rnd;
    logic signed [42:0] q;
    logic [15:0]        out_next, out_reg;

    // Configuration registers; an index beyond the list never occurs with one index bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEED: seed_reg <= cfg_data;
                REG_MODE: mode_reg <= cfg_data[0];
                default:  mode_reg <= mode_reg;
            endcase
        end
    end

    // A stage loads when it is empty or when its contents move on.
    always_comb
    begin
        en[15] = m_tready;
        for (int k = 14; k >= 1; k--)
            en[k] = !valid_reg[k] || en[k + 1];
    end

    assign valid_in = {valid_reg[13:1], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int k = 1; k <= 14; k++)
                if (en[k])
                    valid_reg[k] <= valid_in[k];
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = valid_reg[14];
    assign m_tdata  = out_reg;

    // Stages 1 and 2: skew and split into lattice cell and fraction.
    sn2d_skew u_skew (
        .clk     (clk),
        .en      (en[2:1]),
        .mode    (mode_reg),
        .x_coord ($signed(s_tdata[31:0])),
        .y_coord ($signed(s_tdata[63:32])),
        .cell_x  (cell_x),
        .cell_y  (cell_y),
        .frac_x  (frac_x),
        .frac_y  (frac_y)
    );

    // Stages 3 to 5: lattice hashes inputs and corner offsets.
    sn2d_lattice u_lattice (
        .clk    (clk),
        .en     (en[5:3]),
        .seed   (seed_reg),
        .cell_x (cell_x),
        .cell_y (cell_y),
        .frac_x (frac_x),
        .frac_y (frac_y),
        .hash0  (hash0),
        .hash1  (hash1),
        .hash2  (hash2),
        .dx0    (dx0),
        .dy0    (dy0),
        .dx1    (dx1),
        .dy1    (dy1),
        .dx2    (dx2),
        .dy2    (dy2),
        .slope  (slope)
    );

    // Stages 6 and 7: falloff of the three corners, ready when the corners need it.
    sn2d_falloff u_falloff (
        .clk   (clk),
        .en    (en[7:6]),
        .dx0   (dx0),
        .dy0   (dy0),
        .dx2   (dx2),
        .dy2   (dy2),
        .slope (slope),
        .a0    (a0),
        .a1    (a1),
        .a2    (a2)
    );

    // Stages 6 to 11: one unit per corner, hash to gradient to contribution.
    sn2d_corner u_corner0 (
        .clk     (clk),
        .en      (en[11:6]),
        .hash_in (hash0),
        .dx      (dx0),
        .dy      (dy0),
        .a       (a0),
        .contrib (c0)
    );

    sn2d_corner u_corner1 (
        .clk     (clk),
        .en      (en[11:6]),
        .hash_in (hash1),
        .dx      (dx1),
        .dy      (dy1),
        .a       (a1),
        .contrib (c1)
    );

    sn2d_corner u_corner2 (
        .clk     (clk),
        .en      (en[11:6]),
        .hash_in (hash2),
        .dx      (dx2),
        .dy      (dy2),
        .a       (a2),
        .contrib (c2)
    );

    // Stage 12: sum of the three corner terms in Q.44.
    always_ff @(posedge clk)
    begin
        if (en[12])
            acc_reg <= 63'(c0) + 63'(c1) + 63'(c2);
    end

    // Stage 13: back to Q.22, then scale by the reciprocal normalizer in Q.16.
    assign acc_rnd = acc_reg + 63'sd2097152;

    always_ff @(posedge clk)
    begin
        if (en[13])
            vn_reg <= $signed(acc_rnd[62:22]) * Q16_NORM_INV;
    end

    // Stage 14: round to Q1.15 and saturate.
    always_comb
    begin
        vn_rnd = {vn_reg[64], vn_reg} + 66'sd4194304;
        q      = vn_rnd[65:23];
        if (q > 43'sd32767)
            out_next = 16'h7FFF;
        else if (q < -43'sd32768)
            out_next = 16'h8000;
        else
            out_next = q[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[14])
            out_reg <= out_next;
    end

endmodule
`default_nettype wire

[hdl/sn2d_skew.sv]
`default_nettype none
module sn2d_skew (
    input  logic               clk,
    input  logic [1:0]         en,
    input  logic               mode,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    output logic signed [19:0] cell_x,
    output logic signed [19:0] cell_y,
    output logic [21:0]        frac_x,
    output logic [21:0]        frac_y
);
    import sn2d_pkg::*;

    logic signed [32:0] opa;
    logic signed [23:0] coa;
    logic signed [56:0] pa_next, pa_reg;
    logic signed [55:0] pb_next, pb_reg;
    logic signed [31:0] x_reg, y_reg;
    logic               mode_reg;
    logic signed [57:0] xs, ys;

    // Stage one: the skew products.
    always_comb
    begin
        if (mode)
        begin
            opa = {x_coord[31], x_coord};
            coa = Q22_ROOT_HALF;
        end
        else
        begin
            opa = {x_coord[31], x_coord} + {y_coord[31], y_coord};
            coa = Q22_SKEW;
        end
        pa_next = opa * coa;
        pb_next = y_coord * Q22_ROOT_THREE_HALVES;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            x_reg    <= x_coord;
            y_reg    <= y_coord;
            mode_reg <= mode;
        end
    end

    // Stage two: skewed point in Q.38, split into cell and fraction.
    always_comb
    begin
        if (mode_reg)
        begin
            xs = {{2{pb_reg[55]}}, pb_reg} + {pa_reg[56], pa_reg};
            ys = {{2{pb_reg[55]}}, pb_reg} - {pa_reg[56], pa_reg};
        end
        else
        begin
            xs = {{4{x_reg[31]}}, x_reg, 22'b0} + {pa_reg[56], pa_reg};
            ys = {{4{y_reg[31]}}, y_reg, 22'b0} + {pa_reg[56], pa_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cell_x <= xs[57:38];
            cell_y <= ys[57:38];
            frac_x <= xs[37:16];
            frac_y <= ys[37:16];
        end
    end

endmodule
`default_nettype wire

[hdl/sn2d_lattice.sv]
`default_nettype none
module sn2d_lattice (
    input  logic               clk,
    input  logic [2:0]         en,
    input  logic [63:0]        seed,
    input  logic signed [19:0] cell_x,
    input  logic signed [19:0] cell_y,
    input  logic [21:0]        frac_x,
    input  logic [21:0]        frac_y,
    output logic [63:0]        hash0,
    output logic [63:0]        hash1,
    output logic [63:0]        hash2,
    output sn2d_pkg::ofs_t     dx0,
    output sn2d_pkg::ofs_t     dy0,
    output sn2d_pkg::ofs_t     dx1,
    output sn2d_pkg::ofs_t     dy1,
    output sn2d_pkg::ofs_t     dx2,
    output sn2d_pkg::ofs_t     dy2,
    output sn2d_pkg::slope_t   slope
);
    import sn2d_pkg::*;

    logic signed [52:0] xlo_next, xlo_reg, ylo_next, ylo_reg;
    logic signed [52:0] xhi_full, yhi_full;
    logic [31:0]        xhi_reg, yhi_reg;
    logic signed [23:0] fsum;
    logic signed [47:0] tp_next, tp_reg, tr;
    logic [21:0]        fx_reg, fy_reg;
    logic [63:0]        xp_next, xp_reg, yp_next, yp_reg;
    logic [63:0]        xp1, yp1;
    ofs_t               t_next, t_reg, dx0_next, dx0_reg, dy0_next, dy0_reg;
    logic               upper;

    // Stage three: prime products split in 32-bit halves, unskew product.
    always_comb
    begin
        xlo_next = cell_x * $signed({1'b0, PRIME_X[31:0]});
        ylo_next = cell_y * $signed({1'b0, PRIME_Y[31:0]});
        xhi_full = cell_x * $signed({1'b0, PRIME_X[63:32]});
        yhi_full = cell_y * $signed({1'b0, PRIME_Y[63:32]});
        fsum     = $signed({2'b0, frac_x} + {2'b0, frac_y});
        tp_next  = fsum * Q22_UNSKEW;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xlo_reg <= xlo_next;
            ylo_reg <= ylo_next;
            xhi_reg <= xhi_full[31:0];
            yhi_reg <= yhi_full[31:0];
            tp_reg  <= tp_next;
            fx_reg  <= frac_x;
            fy_reg  <= frac_y;
        end
    end

    // Stage four: full 64-bit lattice products, first corner offsets.
    always_comb
    begin
        xp_next  = {{11{xlo_reg[52]}}, xlo_reg} + {xhi_reg, 32'b0};
        yp_next  = {{11{ylo_reg[52]}}, ylo_reg} + {yhi_reg, 32'b0};
        tr       = tp_reg + 48'sd2097152;
        t_next   = tr[47:22];
        dx0_next = $signed({4'b0, fx_reg}) + t_next;
        dy0_next = $signed({4'b0, fy_reg}) + t_next;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            xp_reg  <= xp_next;
            yp_reg  <= yp_next;
            t_reg   <= t_next;
            dx0_reg <= dx0_next;
            dy0_reg <= dy0_next;
        end
    end

    // Stage five: the third corner follows the larger of dy0 and dx0.
    always_comb
    begin
        upper = dy0_reg > dx0_reg;
        xp1   = xp_reg + PRIME_X;
        yp1   = yp_reg + PRIME_Y;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            hash0 <= seed ^ xp_reg ^ yp_reg;
            hash1 <= seed ^ xp1 ^ yp1;
            hash2 <= upper ? (seed ^ xp_reg ^ yp1) : (seed ^ xp1 ^ yp_reg);
            dx0   <= dx0_reg;
            dy0   <= dy0_reg;
            dx1   <= dx0_reg - Q22_DIAG;
            dy1   <= dy0_reg - Q22_DIAG;
            dx2   <= upper ? (dx0_reg - Q22_UNSKEW) : (dx0_reg - Q22_UNSKEW_P1);
            dy2   <= upper ? (dy0_reg - Q22_UNSKEW_P1) : (dy0_reg - Q22_UNSKEW);
            slope <= t_reg * Q22_A1_SLOPE;
        end
    end

endmodule
`default_nettype wire

[hdl/sn2d_falloff.sv]
`default_nettype none
module sn2d_falloff (
    input  logic             clk,
    input  logic [1:0]       en,
    input  sn2d_pkg::ofs_t   dx0,
    input  sn2d_pkg::ofs_t   dy0,
    input  sn2d_pkg::ofs_t   dx2,
    input  sn2d_pkg::ofs_t   dy2,
    input  sn2d_pkg::slope_t slope,
    output sn2d_pkg::fall_t  a0,
    output sn2d_pkg::fall_t  a1,
    output sn2d_pkg::fall_t  a2
);
    import sn2d_pkg::*;

    logic signed [51:0] sq0x_reg, sq0y_reg, sq2x_reg, sq2y_reg;
    slope_t             slope_reg;
    logic signed [52:0] srnd;
    logic signed [31:0] f0, f1, f2;
    fall_t              a0_reg, a1_reg, a2_reg;

    function automatic logic signed [30:0] rnd22(input logic signed [51:0] v);
        logic signed [52:0] s;
        s = {v[51], v} + 53'sd2097152;
        return s[52:22];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sq0x_reg  <= dx0 * dx0;
            sq0y_reg  <= dy0 * dy0;
            sq2x_reg  <= dx2 * dx2;
            sq2y_reg  <= dy2 * dy2;
            slope_reg <= slope;
        end
    end

    // The second corner's falloff is derived from the first one.
    always_comb
    begin
        f0   = Q22_RSQ - rnd22(sq0x_reg) - rnd22(sq0y_reg);
        f2   = Q22_RSQ - rnd22(sq2x_reg) - rnd22(sq2y_reg);
        srnd = {slope_reg[51], slope_reg} + 53'sd2097152;
        f1   = $signed(srnd[52:22]) + Q22_A1_BASE + f0;
    end

    // A corner whose falloff is not positive gets zero, which zeroes its term.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            a0_reg <= (f0 > 32'sd0) ? f0[23:0] : '0;
            a1_reg <= (f1 > 32'sd0) ? f1[23:0] : '0;
            a2_reg <= (f2 > 32'sd0) ? f2[23:0] : '0;
        end
    end

    assign a0 = a0_reg;
    assign a1 = a1_reg;
    assign a2 = a2_reg;

endmodule
`default_nettype wire

[hdl/sn2d_corner.sv]
`default_nettype none
module sn2d_corner (
    input  logic               clk,
    input  logic [5:0]         en,
    input  logic [63:0]        hash_in,
    input  sn2d_pkg::ofs_t     dx,
    input  sn2d_pkg::ofs_t     dy,
    input  sn2d_pkg::fall_t    a,
    output sn2d_pkg::contrib_t contrib
);
    import sn2d_pkg::*;

    logic [63:0]        plo_reg;
    logic [31:0]        m1_next, m2_next, m1_reg, m2_reg;
    logic [63:0]        h;
    logic [6:0]         idx_reg;
    ofs_t               dx6_reg, dy6_reg, dx7_reg, dy7_reg, dx8_reg, dy8_reg;
    grad_t              gx_reg, gy_reg;
    logic [47:0]        aa_reg;
    logic [48:0]        aa_rnd;
    logic [26:0]        a2;
    logic signed [49:0] px_reg, py_reg;
    logic [53:0]        a2sq_reg;
    logic [54:0]        a4_rnd;
    logic signed [50:0] dsum;
    logic signed [28:0] dot_reg;
    logic [30:0]        a4_reg;

    assign m1_next = hash_in[31:0] * HASH_MULT[63:32];
    assign m2_next = hash_in[63:32] * HASH_MULT[31:0];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            plo_reg <= hash_in[31:0] * HASH_MULT[31:0];
            m1_reg  <= m1_next;
            m2_reg  <= m2_next;
            dx6_reg <= dx;
            dy6_reg <= dy;
        end
    end

    // The index mixes the low hash bits with the sign-filled top bits.
    assign h = plo_reg + {m1_reg + m2_reg, 32'b0};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            idx_reg <= h[7:1] ^ {h[63], h[63], h[63], h[62], h[61], h[60], h[59]};
            dx7_reg <= dx6_reg;
            dy7_reg <= dy6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            gx_reg  <= grad_x(mod24(idx_reg));
            gy_reg  <= grad_y(mod24(idx_reg));
            aa_reg  <= a * a;
            dx8_reg <= dx7_reg;
            dy8_reg <= dy7_reg;
        end
    end

    always_comb
    begin
        aa_rnd = {1'b0, aa_reg} + 49'd2097152;
        a2     = aa_rnd[48:22];
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            px_reg   <= gx_reg * dx8_reg;
            py_reg   <= gy_reg * dy8_reg;
            a2sq_reg <= a2 * a2;
        end
    end

    always_comb
    begin
        dsum   = {px_reg[49], px_reg} + {py_reg[49], py_reg} + 51'sd2097152;
        a4_rnd = {1'b0, a2sq_reg} + 55'd2097152;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            dot_reg <= dsum[50:22];
            a4_reg  <= a4_rnd[52:22];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
            contrib <= $signed({1'b0, a4_reg}) * dot_reg;
    end

endmodule
`default_nettype wire
